FILE: sv/base64_codec_assert.svh
// ----------------------------------------------------------------------------
// base64_codec assertion macros
// shared property forms for the codec checker
// ----------------------------------------------------------------------------
`ifndef BASE64_CODEC_ASSERT_SVH
`define BASE64_CODEC_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define B64C_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("base64_codec check failed");

// next-cycle implication, sampled on clk, off while in reset
`define B64C_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("base64_codec check failed");

`endif

FILE: sv/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg
// types, constants and alphabet functions of the base64 codec
// ----------------------------------------------------------------------------
package b64c_pkg;

	localparam int GROUP_W  = 24;
	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [5:0] SEXT_UPPER_MAX = 6'h19;
	localparam logic [5:0] SEXT_LOWER_BASE = 6'h1A;
	localparam logic [5:0] SEXT_LOWER_MAX = 6'h33;
	localparam logic [5:0] SEXT_DIGIT_BASE = 6'h34;
	localparam logic [5:0] SEXT_DIGIT_MAX = 6'h3D;
	localparam logic [5:0] SEXT_PLUS = 6'h3E;
	localparam logic [5:0] SEXT_SLASH = 6'h3F;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PAD = 8'h3D;

	typedef struct packed {
		logic [7:0] data_in;
		logic       flush;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       last;
	} out_item_t;

	// one emitted group handed from front to back
	typedef struct packed {
		logic [GROUP_W-1:0] grp;
		logic               dir;
		logic [2:0]         nreal;
		logic [2:0]         nres;
	} grp_rec_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sext_t;

	function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
		logic [7:0] c;
		if (v <= SEXT_UPPER_MAX)
			c = CH_UPPER_A + {2'b00, v};
		else if (v <= SEXT_LOWER_MAX)
			c = CH_LOWER_A + {2'b00, v - SEXT_LOWER_BASE};
		else if (v <= SEXT_DIGIT_MAX)
			c = CH_DIGIT_0 + {2'b00, v - SEXT_DIGIT_BASE};
		else if (v == SEXT_PLUS)
			c = CH_PLUS;
		else
			c = CH_SLASH;
		return c;
	endfunction

	function automatic sext_t char_to_sextet(input logic [7:0] c);
		sext_t r;
		logic [7:0] d;
		r = '0;
		d = '0;
		if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
			d = c - CH_UPPER_A;
			r.ok = 1'b1;
			r.val = d[5:0];
		end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
			d = c - CH_LOWER_A;
			r.ok = 1'b1;
			r.val = d[5:0] + SEXT_LOWER_BASE;
		end else if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
			d = c - CH_DIGIT_0;
			r.ok = 1'b1;
			r.val = d[5:0] + SEXT_DIGIT_BASE;
		end else if (c == CH_PLUS) begin
			r.ok = 1'b1;
			r.val = SEXT_PLUS;
		end else if (c == CH_SLASH) begin
			r.ok = 1'b1;
			r.val = SEXT_SLASH;
		end
		return r;
	endfunction

endpackage

FILE: sv/base64_codec.sv
// ----------------------------------------------------------------------------
// base64_codec
// base64 encoder and decoder over a 24-bit group register
// ----------------------------------------------------------------------------
//
//  channel  direction  signals                       payload
//  in       sink       in_valid, in_stall            in_data (data_in, flush)
//  out      source     out_valid, out_stall          out_data (data_out, last)
//  cfg      sink       cfg_wr_en                     cfg_wr_data (direction)
//
// a request is taken every cycle while the group queue has room; each result
// leaves the serialiser at one a cycle while out_stall is low, so a full encode group
// of three bytes drains as four characters and the queue absorbs the difference.
// first result of a group passes the queue entry, grp_q and out_q in turn.
// reset clears the group, the queue, the output valid flag and sets encode mode.
// output stall backs up the two-entry queue, then in_stall rises.
//
module base64_codec import b64c_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic     direction_q;
	logic     q_full;
	logic     q_push;
	logic     q_pop;
	logic     q_nonempty;
	grp_rec_t q_rec;
	grp_rec_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			direction_q <= DIR_ENCODE;
		else if (cfg_wr_en)
			direction_q <= cfg_wr_data;
	end

	b64c_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.direction (direction_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_rec     (q_rec)
	);

	b64c_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_rec),
		.pop      (q_pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	b64c_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

FILE: sv/b64c_front.sv
// ----------------------------------------------------------------------------
// b64c_front
// accepts requests, packs bits into the group and queues full or flushed groups
// ----------------------------------------------------------------------------
module b64c_front import b64c_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     direction,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     q_push,
	output grp_rec_t q_rec
);

	logic [GROUP_W-1:0] grp_q;
	logic [4:0]         bc_q;

	logic               accept;
	sext_t              sx;
	logic               enc;
	logic [GROUP_W-1:0] shifted;
	logic [5:0]         sum;
	logic               take;
	logic               full_grp;
	logic               emit;
	logic [GROUP_W-1:0] emit_grp;
	logic [4:0]         emit_bc;
	logic [2:0]         nreal;
	logic [2:0]         nbytes;

	assign in_stall = q_full;
	assign accept = in_valid && !in_stall;

	always_comb begin
		sx = char_to_sextet(in_data.data_in);
		enc = (direction == DIR_ENCODE);
		if (enc)
			shifted = {in_data.data_in, 16'h0000} >> bc_q;
		else
			shifted = {sx.val, 18'h00000} >> bc_q;
		sum = {1'b0, bc_q} + (enc ? 6'd8 : 6'd6);
		take = !in_data.flush && (enc || sx.ok) && (sum <= 6'(GROUP_W));
		full_grp = take && (sum == 6'(GROUP_W));
		emit = in_data.flush ? (bc_q != 5'd0) : full_grp;
		emit_grp = in_data.flush ? grp_q : (grp_q | shifted);
		emit_bc = in_data.flush ? bc_q : sum[4:0];

		// characters that carry group bits, the rest are padding
		if (emit_bc > 5'd18)
			nreal = 3'd4;
		else if (emit_bc > 5'd12)
			nreal = 3'd3;
		else if (emit_bc > 5'd6)
			nreal = 3'd2;
		else
			nreal = 3'd1;

		if (emit_bc >= 5'd24)
			nbytes = 3'd3;
		else if (emit_bc >= 5'd16)
			nbytes = 3'd2;
		else if (emit_bc >= 5'd8)
			nbytes = 3'd1;
		else
			nbytes = 3'd0;

		q_rec.grp = emit_grp;
		q_rec.dir = direction;
		q_rec.nreal = nreal;
		q_rec.nres = enc ? 3'd4 : nbytes;
	end

	assign q_push = accept && emit && (q_rec.nres != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
			bc_q <= '0;
		end else if (accept) begin
			if (emit || in_data.flush) begin
				grp_q <= '0;
				bc_q <= '0;
			end else if (take) begin
				grp_q <= grp_q | shifted;
				bc_q <= sum[4:0];
			end
		end
	end

endmodule

FILE: sv/b64c_queue.sv
// ----------------------------------------------------------------------------
// b64c_queue
// short fifo of emitted groups between front and back
// ----------------------------------------------------------------------------
module b64c_queue import b64c_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  grp_rec_t push_rec,
	input  logic     pop,
	output logic     full,
	output logic     nonempty,
	output grp_rec_t head
);

	grp_rec_t           ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: sv/b64c_back.sv
// ----------------------------------------------------------------------------
// b64c_back
// serialises a queued group to characters or bytes, one result a cycle unless stalled
// ----------------------------------------------------------------------------
module b64c_back import b64c_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_nonempty,
	input  grp_rec_t  q_head,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic               busy_q;
	logic [GROUP_W-1:0] grp_q;
	logic               dir_q;
	logic [2:0]         real_q;
	logic [2:0]         left_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic      load;
	logic      finish;
	out_item_t item;

	assign load = !out_valid_q || !out_stall;
	assign finish = busy_q && load && (left_q == 3'd1);
	assign q_pop = q_nonempty && (!busy_q || finish);

	always_comb begin
		if (dir_q == DIR_ENCODE)
			item.data_out = (real_q != 3'd0) ? sextet_to_char(grp_q[23:18]) : CH_PAD;
		else
			item.data_out = grp_q[23:16];
		item.last = (left_q == 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				left_q <= q_head.nres;
			end else if (busy_q && load) begin
				left_q <= left_q - 1'b1;
				if (finish)
					busy_q <= 1'b0;
			end
			if (load)
				out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			grp_q <= q_head.grp;
			dir_q <= q_head.dir;
			real_q <= q_head.nreal;
		end else if (busy_q && load) begin
			grp_q <= (dir_q == DIR_ENCODE) ? {grp_q[17:0], 6'h00} : {grp_q[15:0], 8'h00};
			if (real_q != 3'd0)
				real_q <= real_q - 1'b1;
		end
		if (load && busy_q)
			out_q <= item;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

FILE: sv/b64c_checker.sv
// ----------------------------------------------------------------------------
// b64c_checker
// port-level checks on the base64 codec, bound to the top level
// ----------------------------------------------------------------------------
`include "base64_codec_assert.svh"

module b64c_checker import b64c_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cfg_wr_en,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	logic out_take;

	assign out_take = out_valid && !out_stall;

	// a held result keeps its payload
	`B64C_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

	// the rest of a group follows without a gap
	`B64C_ASSERT_NEXT(a_group_cont, out_take && !out_data.last, out_valid)

	// the queue only fills while results are waiting at the output
	`B64C_ASSERT_NOW(a_stall_cause, in_stall, out_valid)

	// a register write with no request arriving cannot fill the queue
	`B64C_ASSERT_NEXT(a_cfg_idle, cfg_wr_en && !out_valid && !in_stall && !in_valid, !in_stall)

endmodule

bind base64_codec b64c_checker u_b64c_checker (.*);
